>>> rtl/rro_pkg.sv
// shared constants for the rotated rectangle overlap test
// cordic widths, arctangent table and pipeline latencies; no dependencies
`default_nettype none
package rro_pkg;
	localparam int TRIG_W        = 16;
	localparam int CORDIC_STEPS  = 24;
	localparam int CORDIC_W      = 34;
	localparam int ZW            = 33;
	localparam int CORDIC_LAT    = CORDIC_STEPS + 2;
	localparam int LANE_LAT      = 4;
	localparam int NUM_LANES     = 4;
	localparam int DEF_COORD_BITS = 24;
	localparam int DEF_ANGLE_BITS = 16;
	localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032875;
	localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};
endpackage
`default_nettype wire

>>> rtl/rotated_rect_overlap_test_unit.sv
// top level of the rotated rectangle overlap test (separating axis test)
// instantiates two rro_cordic units and four rro_lane units; uses rro_pkg
`default_nettype none
// Fully pipelined: a request is taken on every cycle that start is high (busy
// is always low), and its overlap result appears with a one-cycle done strobe
// once the request has passed the cordic pipeline (one rotation step per
// stage, 24 steps), the four-stage axis lanes and one merge register, in
// request order. The receiver cannot stall, so results must be taken as they
// come. overlap is 1 when no axis separates the rectangles; touching counts
// as overlap, and an edge of zero length never separates.
module rotated_rect_overlap_test_unit #(
	parameter int COORD_BITS = rro_pkg::DEF_COORD_BITS,
	parameter int ANGLE_BITS = rro_pkg::DEF_ANGLE_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [COORD_BITS-1:0] first_center_x,
	input  wire logic signed [COORD_BITS-1:0] first_center_y,
	input  wire logic [COORD_BITS-2:0]        first_width,
	input  wire logic [COORD_BITS-2:0]        first_height,
	input  wire logic [ANGLE_BITS-1:0]        first_angle,
	input  wire logic signed [COORD_BITS-1:0] second_center_x,
	input  wire logic signed [COORD_BITS-1:0] second_center_y,
	input  wire logic [COORD_BITS-2:0]        second_width,
	input  wire logic [COORD_BITS-2:0]        second_height,
	input  wire logic [ANGLE_BITS-1:0]        second_angle,
	output logic                              done,
	output logic                              overlap
);
	localparam int CL = rro_pkg::CORDIC_LAT;
	localparam int VL = rro_pkg::CORDIC_LAT + rro_pkg::LANE_LAT;
	localparam int TW = rro_pkg::TRIG_W;
	localparam int NL = rro_pkg::NUM_LANES;

	// no back-pressure anywhere: a request can enter every cycle
	assign busy = 1'b0;

	// side data travels alongside the cordic pipeline
	logic signed [COORD_BITS:0] dcx_q [CL];
	logic signed [COORD_BITS:0] dcy_q [CL];
	logic [COORD_BITS-2:0] wa_q [CL];
	logic [COORD_BITS-2:0] ha_q [CL];
	logic [COORD_BITS-2:0] wb_q [CL];
	logic [COORD_BITS-2:0] hb_q [CL];
	logic [VL-1:0] vld_q;

	always_ff @(posedge clk) begin
		dcx_q[0] <= {first_center_x[COORD_BITS-1], first_center_x}
			- {second_center_x[COORD_BITS-1], second_center_x};
		dcy_q[0] <= {first_center_y[COORD_BITS-1], first_center_y}
			- {second_center_y[COORD_BITS-1], second_center_y};
		wa_q[0] <= first_width;
		ha_q[0] <= first_height;
		wb_q[0] <= second_width;
		hb_q[0] <= second_height;
		for (int i = 1; i < CL; i++) begin
			dcx_q[i] <= dcx_q[i-1];
			dcy_q[i] <= dcy_q[i-1];
			wa_q[i]  <= wa_q[i-1];
			ha_q[i]  <= ha_q[i-1];
			wb_q[i]  <= wb_q[i-1];
			hb_q[i]  <= hb_q[i-1];
		end
	end

	// request valid shift line, one bit per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[VL-2:0], start};
		end
	end

	// cosine and sine of each rectangle
	logic signed [TW-1:0] ca, sa, cb, sb;

	rro_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_a (
		.clk(clk), .angle(first_angle), .cos_val(ca), .sin_val(sa)
	);
	rro_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_b (
		.clk(clk), .angle(second_angle), .cos_val(cb), .sin_val(sb)
	);

	// the four axes: edge directions of each rectangle, unnormalised
	logic signed [TW-1:0] ax [NL];
	logic signed [TW-1:0] ay [NL];
	logic [NL-1:0] used;
	logic [NL-1:0] sep;

	assign ax[0] = ca;  assign ay[0] = sa;
	assign ax[1] = -sa; assign ay[1] = ca;
	assign ax[2] = cb;  assign ay[2] = sb;
	assign ax[3] = -sb; assign ay[3] = cb;

	// a zero-length edge gives no axis
	assign used[0] = wa_q[CL-1] != '0;
	assign used[1] = ha_q[CL-1] != '0;
	assign used[2] = wb_q[CL-1] != '0;
	assign used[3] = hb_q[CL-1] != '0;

	for (genvar k = 0; k < NL; k++) begin : g_lane
		rro_lane #(.COORD_BITS(COORD_BITS)) u_lane (
			.clk(clk),
			.ca(ca), .sa(sa), .cb(cb), .sb(sb),
			.ax(ax[k]), .ay(ay[k]),
			.dcx(dcx_q[CL-1]), .dcy(dcy_q[CL-1]),
			.wa(wa_q[CL-1]), .ha(ha_q[CL-1]),
			.wb(wb_q[CL-1]), .hb(hb_q[CL-1]),
			.used(used[k]),
			.sep(sep[k])
		);
	end

	// merge: any lane that found a gap separates the pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_q[VL-1];
		end
	end

	always_ff @(posedge clk) begin
		overlap <= ~(|sep);
	end
endmodule
`default_nettype wire

>>> rtl/rro_cordic.sv
// pipelined cordic giving cosine and sine (q.14) of a binary angle
// one rotation step per stage; uses rro_pkg
`default_nettype none
module rro_cordic #(
	parameter int ANGLE_BITS = rro_pkg::DEF_ANGLE_BITS
) (
	input  wire logic                                  clk,
	input  wire logic [ANGLE_BITS-1:0]                 angle,
	output logic signed [rro_pkg::TRIG_W-1:0]          cos_val,
	output logic signed [rro_pkg::TRIG_W-1:0]          sin_val
);
	localparam int N  = rro_pkg::CORDIC_STEPS;
	localparam int XW = rro_pkg::CORDIC_W;
	localparam int ZW = rro_pkg::ZW;
	localparam int TW = rro_pkg::TRIG_W;

	logic [31:0] a32;
	logic signed [XW-1:0] x_s [N+1];
	logic signed [XW-1:0] y_s [N+1];
	logic signed [ZW-1:0] z_s [N+1];
	logic [1:0]           quad_s [N+1];
	logic signed [XW-1:0] xr, yr;
	logic signed [TW-1:0] c, s;

	assign a32 = {angle, {(32-ANGLE_BITS){1'b0}}};

	always_ff @(posedge clk) begin
		x_s[0]    <= rro_pkg::CORDIC_START;
		y_s[0]    <= '0;
		z_s[0]    <= {3'b000, a32[29:0]};
		quad_s[0] <= a32[31:30];
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (!z_s[i][ZW-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - $signed({1'b0, rro_pkg::ATAN_TURN[i]});
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + $signed({1'b0, rro_pkg::ATAN_TURN[i]});
			end
			quad_s[i+1] <= quad_s[i];
		end
	end

	// round half up to q.14
	assign xr = x_s[N] + XW'(32768);
	assign yr = y_s[N] + XW'(32768);
	assign c  = xr[31:16];
	assign s  = yr[31:16];

	always_ff @(posedge clk) begin
		case (quad_s[N])
			2'd0: begin cos_val <= c;  sin_val <= s;  end
			2'd1: begin cos_val <= -s; sin_val <= c;  end
			2'd2: begin cos_val <= -c; sin_val <= -s; end
			default: begin cos_val <= s; sin_val <= -c; end
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/rro_lane.sv
// one axis lane: projects both rectangles on one axis and flags a gap
// four-stage pipeline of multiplies, sums and one compare; uses rro_pkg
`default_nettype none
module rro_lane #(
	parameter int COORD_BITS = rro_pkg::DEF_COORD_BITS
) (
	input  wire logic                               clk,
	input  wire logic signed [rro_pkg::TRIG_W-1:0]  ca,
	input  wire logic signed [rro_pkg::TRIG_W-1:0]  sa,
	input  wire logic signed [rro_pkg::TRIG_W-1:0]  cb,
	input  wire logic signed [rro_pkg::TRIG_W-1:0]  sb,
	input  wire logic signed [rro_pkg::TRIG_W-1:0]  ax,
	input  wire logic signed [rro_pkg::TRIG_W-1:0]  ay,
	input  wire logic signed [COORD_BITS:0]         dcx,
	input  wire logic signed [COORD_BITS:0]         dcy,
	input  wire logic [COORD_BITS-2:0]              wa,
	input  wire logic [COORD_BITS-2:0]              ha,
	input  wire logic [COORD_BITS-2:0]              wb,
	input  wire logic [COORD_BITS-2:0]              hb,
	input  wire logic                               used,
	output logic                                    sep
);
	localparam int TW  = rro_pkg::TRIG_W;
	localparam int PW  = 2*TW;
	localparam int SW  = COORD_BITS - 1;
	localparam int MW  = COORD_BITS + 1 + TW;
	localparam int DW  = COORD_BITS + 33;
	localparam int RW  = SW + 32;

	// stage 1: trig by axis and centre offset by axis
	logic signed [PW-1:0] pac_s1, pas_s1, qas_s1, qac_s1;
	logic signed [PW-1:0] pbc_s1, pbs_s1, qbs_s1, qbc_s1;
	logic signed [MW-1:0] mx_s1, my_s1;
	logic [SW-1:0] wa_s1, ha_s1, wb_s1, hb_s1;
	logic used_s1;

	always_ff @(posedge clk) begin
		pac_s1 <= ca * ax;  pas_s1 <= sa * ay;
		qas_s1 <= sa * ax;  qac_s1 <= ca * ay;
		pbc_s1 <= cb * ax;  pbs_s1 <= sb * ay;
		qbs_s1 <= sb * ax;  qbc_s1 <= cb * ay;
		mx_s1  <= MW'(dcx) * MW'(ax);
		my_s1  <= MW'(dcy) * MW'(ay);
		wa_s1 <= wa; ha_s1 <= ha; wb_s1 <= wb; hb_s1 <= hb;
		used_s1 <= used;
	end

	// stage 2: half-extent factors and scaled centre distance
	logic signed [PW:0] aa_s2, ba_s2, ab_s2, bb_s2;
	logic signed [DW-1:0] d_s2;
	logic signed [MW:0] msum;
	logic [SW-1:0] wa_s2, ha_s2, wb_s2, hb_s2;
	logic used_s2;

	assign msum = {mx_s1[MW-1], mx_s1} + {my_s1[MW-1], my_s1};

	always_ff @(posedge clk) begin
		aa_s2 <= {pac_s1[PW-1], pac_s1} + {pas_s1[PW-1], pas_s1};
		ba_s2 <= {qac_s1[PW-1], qac_s1} - {qas_s1[PW-1], qas_s1};
		ab_s2 <= {pbc_s1[PW-1], pbc_s1} + {pbs_s1[PW-1], pbs_s1};
		bb_s2 <= {qbc_s1[PW-1], qbc_s1} - {qbs_s1[PW-1], qbs_s1};
		d_s2  <= {msum, 15'b0};
		wa_s2 <= wa_s1; ha_s2 <= ha_s1; wb_s2 <= wb_s1; hb_s2 <= hb_s1;
		used_s2 <= used_s1;
	end

	// stage 3: extent products and distance magnitude
	logic [PW:0] ua, va, ub, vb;
	logic [DW-1:0] dmag;
	logic [RW-1:0] r0_s3, r1_s3, r2_s3, r3_s3;
	logic [DW-1:0] dabs_s3;
	logic used_s3;

	assign ua   = aa_s2[PW] ? -aa_s2 : aa_s2;
	assign va   = ba_s2[PW] ? -ba_s2 : ba_s2;
	assign ub   = ab_s2[PW] ? -ab_s2 : ab_s2;
	assign vb   = bb_s2[PW] ? -bb_s2 : bb_s2;
	assign dmag = d_s2[DW-1] ? -d_s2 : d_s2;

	always_ff @(posedge clk) begin
		r0_s3 <= RW'(wa_s2) * RW'(ua[31:0]);
		r1_s3 <= RW'(ha_s2) * RW'(va[31:0]);
		r2_s3 <= RW'(wb_s2) * RW'(ub[31:0]);
		r3_s3 <= RW'(hb_s2) * RW'(vb[31:0]);
		dabs_s3 <= dmag;
		used_s3 <= used_s2;
	end

	// stage 4: gap when distance exceeds the summed half-extents
	logic [DW-1:0] rsum;
	assign rsum = DW'(r0_s3) + DW'(r1_s3) + DW'(r2_s3) + DW'(r3_s3);

	always_ff @(posedge clk) begin
		sep <= used_s3 && (dabs_s3 > rsum);
	end
endmodule
`default_nettype wire

>>> test/tb_top.sv
// self-checking testbench for rotated_rect_overlap_test_unit (separating axis test)
// drives rectangle pairs, predicts overlap with its own cordic and projection model
// depends on rtl/rotated_rect_overlap_test_unit.sv and the rtl/ files it uses
`timescale 1ns / 100ps

module tb_top;

	typedef struct packed {
		logic signed [23:0] cx;
		logic signed [23:0] cy;
		logic [22:0]        w;
		logic [22:0]        h;
		logic [15:0]        ang;
	} rect_t;

	// binary angles, a full turn being 2^16
	localparam logic [15:0] ANG_0   = 16'h0000;
	localparam logic [15:0] ANG_45  = 16'h2000;
	localparam logic [15:0] ANG_90  = 16'h4000;
	localparam logic [15:0] ANG_180 = 16'h8000;
	localparam logic [15:0] ANG_270 = 16'hC000;

	// arctangent of 2^-i in 32-bit turn units
	localparam longint ARC_TAB [24] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
		64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F,
		64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
	};
	localparam longint GAIN_Q30 = 652032875;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	rect_t rect_a = '0;
	rect_t rect_b = '0;
	wire   busy;
	wire   done;
	wire   overlap;

	bit    overlap_q[$];
	int    mismatches = 0;
	bit    idle_on = 1'b1;

	always #2 clk = ~clk;

	rotated_rect_overlap_test_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_center_x(rect_a.cx), .first_center_y(rect_a.cy),
		.first_width(rect_a.w), .first_height(rect_a.h), .first_angle(rect_a.ang),
		.second_center_x(rect_b.cx), .second_center_y(rect_b.cy),
		.second_width(rect_b.w), .second_height(rect_b.h), .second_angle(rect_b.ang),
		.done(done), .overlap(overlap)
	);

	// cosine and sine in Q.14: cordic over the angle within its quadrant,
	// then the quadrant applied by swaps and negations
	function automatic void cordic_trig(input logic [15:0] ang, output longint co,
			output longint si);
		longint      x, y, z, dx, dy, c, s;
		logic [31:0] a32;
		a32 = {ang, 16'h0000};
		z   = longint'(a32 & 32'h3FFF_FFFF);
		x   = GAIN_Q30;
		y   = 0;
		for (int i = 0; i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ARC_TAB[i];
			end else begin
				x += dx; y -= dy; z += ARC_TAB[i];
			end
		end
		c = (x + (64'sd1 <<< 15)) >>> 16;
		s = (y + (64'sd1 <<< 15)) >>> 16;
		case (a32[31:30])
			2'd0: begin co = c;  si = s;  end
			2'd1: begin co = -s; si = c;  end
			2'd2: begin co = -c; si = -s; end
			default: begin co = s; si = -c; end
		endcase
	endfunction

	// corners held as twice the coordinate in Q.14, order p0..p3
	function automatic void rect_corners(input rect_t r, output longint px[4],
			output longint py[4], output longint co, output longint si);
		longint cx, cy, w, h, u, v;
		cordic_trig(r.ang, co, si);
		cx = longint'($signed(r.cx)) * 32768;
		cy = longint'($signed(r.cy)) * 32768;
		w  = longint'(r.w);
		h  = longint'(r.h);
		for (int k = 0; k < 4; k++) begin
			u = (k == 0 || k == 3) ? -w : w;
			v = (k < 2) ? -h : h;
			px[k] = cx + u * co - v * si;
			py[k] = cy + u * si + v * co;
		end
	endfunction

	function automatic void axis_span(input longint px[4], input longint py[4],
			input longint ax, input longint ay, output longint lo, output longint hi);
		longint p;
		lo = px[0] * ax + py[0] * ay;
		hi = lo;
		for (int k = 1; k < 4; k++) begin
			p = px[k] * ax + py[k] * ay;
			if (p < lo) lo = p;
			if (p > hi) hi = p;
		end
	endfunction

	function automatic bit predict_overlap(input rect_t a, input rect_t b);
		longint apx[4], apy[4], bpx[4], bpy[4];
		longint ac, as_, bc, bs, alo, ahi, blo, bhi;
		longint axx[4], axy[4];
		bit     live[4];
		rect_corners(a, apx, apy, ac, as_);
		rect_corners(b, bpx, bpy, bc, bs);
		axx = '{ac, -as_, bc, -bs};
		axy = '{as_, ac, bs, bc};
		live = '{a.w != 0, a.h != 0, b.w != 0, b.h != 0};
		// a zero-length edge gives a null axis and is skipped
		for (int k = 0; k < 4; k++) begin
			if (live[k]) begin
				axis_span(apx, apy, axx[k], axy[k], alo, ahi);
				axis_span(bpx, bpy, axx[k], axy[k], blo, bhi);
				if (ahi < blo || bhi < alo) return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		$display("tb: mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// result checker: every done strobe must match the oldest pending request
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (overlap_q.size() == 0)
				report_mismatch("result with no request outstanding");
			else begin
				bit exp_ov;
				exp_ov = overlap_q.pop_front();
				if (overlap !== exp_ov)
					report_mismatch($sformatf("overlap got %b want %b", overlap, exp_ov));
			end
		end
	end

	task automatic idle_cycles(input int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// sends one request and waits for it to be taken
	task automatic send_pair(input rect_t a, input rect_t b);
		bit took;
		if (idle_on && $urandom_range(0, 3) == 0)
			idle_cycles($urandom_range(1, 16));
		@(negedge clk);
		start  <= 1'b1;
		rect_a <= a;
		rect_b <= b;
		do begin
			@(posedge clk);
			took = !busy;
		end while (!took);
		overlap_q.push_back(predict_overlap(a, b));
	endtask

	function automatic rect_t mk_rect(input int cx, input int cy, input int w, input int h,
			input logic [15:0] ang);
		rect_t r;
		r.cx = 24'(cx); r.cy = 24'(cy); r.w = 23'(w); r.h = 23'(h); r.ang = ang;
		return r;
	endfunction

	function automatic rect_t rand_rect_full();
		rect_t r;
		r.cx = 24'($urandom); r.cy = 24'($urandom);
		r.w = 23'($urandom); r.h = 23'($urandom); r.ang = 16'($urandom);
		return r;
	endfunction

	// pair placed close together at a random scale, so both outcomes are common
	task automatic send_near_pair();
		rect_t a, b;
		int    e, span;
		e    = $urandom_range(1, 22);
		span = 1 << e;
		a.cx = 24'($urandom); a.cy = 24'($urandom);
		a.w  = 23'($urandom_range(0, span - 1));
		a.h  = 23'($urandom_range(0, span - 1));
		a.ang = 16'($urandom);
		b.w  = 23'($urandom_range(0, span - 1));
		b.h  = 23'($urandom_range(0, span - 1));
		b.ang = ($urandom_range(0, 3) == 0) ? (a.ang ^ 16'($urandom_range(0, 3) << 14))
			: 16'($urandom);
		b.cx = 24'(a.cx + $signed($urandom_range(0, 2 * span)) - span);
		b.cy = 24'(a.cy + $signed($urandom_range(0, 2 * span)) - span);
		if ($urandom_range(0, 1)) send_pair(a, b);
		else send_pair(b, a);
	endtask

	task automatic wait_drained();
		while (overlap_q.size() != 0) @(negedge clk);
	endtask

	// field extremes and all-zero / all-one patterns
	task automatic test_extremes();
		send_pair('0, '0);
		send_pair('1, '1);
		send_pair(mk_rect(-8388608, -8388608, 8388607, 8388607, 16'hFFFF),
			mk_rect(8388607, 8388607, 8388607, 8388607, ANG_0));
		send_pair(mk_rect(-8388608, 8388607, 0, 0, ANG_0),
			mk_rect(8388607, -8388608, 0, 0, 16'hFFFF));
		send_pair(mk_rect(-8388608, -8388608, 1, 1, ANG_0),
			mk_rect(8388607, 8388607, 1, 1, ANG_0));
	endtask

	// the quadrant boundaries and a diagonal
	task automatic test_quadrants();
		logic [15:0] angs [6] = '{ANG_0, ANG_45, ANG_90, ANG_180, ANG_270, 16'hFFFF};
		foreach (angs[i])
			send_pair(mk_rect(0, 0, 2048, 512, angs[i]), mk_rect(1100, 0, 256, 256, ANG_0));
	endtask

	// touching edges count as overlap, a one-lsb gap separates
	task automatic test_touching();
		send_pair(mk_rect(0, 0, 512, 512, ANG_0), mk_rect(512, 0, 512, 512, ANG_0));
		send_pair(mk_rect(0, 0, 512, 512, ANG_0), mk_rect(513, 0, 512, 512, ANG_0));
		send_pair(mk_rect(0, 0, 512, 512, ANG_90), mk_rect(0, -512, 512, 512, ANG_180));
		send_pair(mk_rect(0, 0, 512, 512, ANG_0), mk_rect(0, 514, 512, 512, ANG_270));
	endtask

	// zero-length edges: points and segments
	task automatic test_degenerate();
		send_pair(mk_rect(100, 100, 0, 0, ANG_0), mk_rect(100, 100, 0, 0, ANG_45));
		send_pair(mk_rect(100, 100, 0, 0, ANG_0), mk_rect(101, 100, 0, 0, ANG_0));
		send_pair(mk_rect(0, 0, 1024, 0, ANG_0), mk_rect(0, 0, 0, 1024, ANG_0));
		send_pair(mk_rect(0, 0, 1024, 0, ANG_45), mk_rect(400, 0, 0, 1024, ANG_0));
		send_pair(mk_rect(0, 0, 0, 300, ANG_0), mk_rect(0, 200, 256, 256, ANG_45));
	endtask

	// hold off until the pipeline has emptied, then resume
	task automatic test_drain_pause();
		repeat (6) send_near_pair();
		@(negedge clk);
		start <= 1'b0;
		wait_drained();
		repeat (5) send_near_pair();
	endtask

	task automatic test_random(input int n);
		repeat (n) begin
			if ($urandom_range(0, 9) < 3) send_pair(rand_rect_full(), rand_rect_full());
			else send_near_pair();
		end
	endtask

	// final stretch with no gaps between requests
	task automatic test_back_to_back(input int n);
		idle_on = 1'b0;
		test_random(n);
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		test_extremes();
		test_quadrants();
		test_touching();
		test_degenerate();
		test_drain_pause();
		test_random(1250);
		test_back_to_back(180);
		@(negedge clk);
		start <= 1'b0;
		wait_drained();
		repeat (40) @(negedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// generous bound on the whole run
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule

>>> files.f
rtl/rro_pkg.sv
rtl/rro_cordic.sv
rtl/rro_lane.sv
rtl/rotated_rect_overlap_test_unit.sv
test/tb_top.sv
